// ===== src/msfsec_pkg.sv =====
// Shared constants and types for the MSF timecode to sector number converter.
package msfsec_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned ACC_W   = 31;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned REM_W   = 13;
	localparam int unsigned PROD_W  = 44;
	localparam int unsigned TDATA_W = 32;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [REM_W-1:0]  rem_t;
	typedef logic [PROD_W-1:0] prod_t;

	// Field position codes
	typedef logic [1:0] field_t;
	localparam field_t FIELD_MIN    = 2'd0;
	localparam field_t FIELD_SEC    = 2'd1;
	localparam field_t FIELD_FRM    = 2'd2;
	localparam field_t FIELD_UNUSED = 2'd3;

	// Character codes
	localparam char_t CHAR_TERM  = 8'h00;
	localparam char_t CHAR_COLON = 8'h3A;
	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_NINE  = 8'h39;

	localparam acc_t  SECS_PER_MIN   = 31'd60;
	localparam acc_t  FRAMES_PER_SEC = 31'd75;
	localparam prod_t FRAMES_PER_MIN = 44'd4500;
	localparam rem_t  FRAMES_PER_SEC_R = 13'd75;

	// Status bit codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

endpackage

// ===== src/msf_timecode_to_sector_unit.sv =====
// Top level of the MSF timecode to sector number converter.
//
// Feed a timecode string "minutes:seconds:frames" one ASCII character per
// input transaction on the s_ side; a zero byte ends the string and produces
// exactly one output transaction on the m_ side carrying the sector number
// minutes*4500 + seconds*75 + frames and a status bit. Each field needs at
// least one decimal digit and fields are separated by single colons. Any bad
// character, misplaced colon, missing digit, seconds of 60 or more, frames of
// 75 or more, a field above 2^31-1 or a sum above 2^31-1 gives status 1 with a
// sector number of 0; the error is held until the terminator, which always
// returns the parser to its reset state. The block takes one character every
// cycle while later stages have room. A result goes from the input register
// through the parser snapshot and the minutes*4500 multiplier to the add and
// range check of the output register. Each stage has its own valid bit, so
// input is still taken while a result waits in the output register.
module msf_timecode_to_sector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [30:0] sector_number, [31] zero
	output logic        m_tuser    // [0] status
);

	// ---------------- stage handshakes ----------------
	logic valid_s1, valid_s2, valid_s3;
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;

	// Each stage moves forward when the next one is empty or moving too.
	assign rdy_out  = !m_tvalid || m_tready;
	assign rdy_s3   = !valid_s3 || rdy_out;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// ---------------- input register ----------------
	msfsec_pkg::char_t char_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	// ---------------- parser state ----------------
	msfsec_pkg::field_t fpos_q;
	logic               seen_q;
	logic               err_q;
	msfsec_pkg::acc_t   min_q, sec_q, frm_q;

	// Consume the character in stage 1 only when stage 2 can take a result.
	logic take_s1;
	assign take_s1 = valid_s1 && rdy_s2;

	logic                     is_term, is_digit, is_colon;
	logic [msfsec_pkg::DIGIT_W-1:0] digit;
	msfsec_pkg::acc_t         cur_acc;
	logic                     cur_bad;
	logic [msfsec_pkg::ACC_W+3:0] acc_next;
	logic                     acc_ovf;
	logic                     term_bad;
	msfsec_pkg::rem_t         rem_val;

	always_comb begin
		is_term  = (char_s1 == msfsec_pkg::CHAR_TERM);
		is_colon = (char_s1 == msfsec_pkg::CHAR_COLON);
		is_digit = char_s1 inside {[msfsec_pkg::CHAR_ZERO:msfsec_pkg::CHAR_NINE]};
		digit    = msfsec_pkg::DIGIT_W'(char_s1 - msfsec_pkg::CHAR_ZERO);

		// Select the field being accumulated; the unused position is an error.
		cur_bad = 1'b0;
		case (fpos_q)
			msfsec_pkg::FIELD_MIN: cur_acc = min_q;
			msfsec_pkg::FIELD_SEC: cur_acc = sec_q;
			msfsec_pkg::FIELD_FRM: cur_acc = frm_q;
			default: begin
				cur_acc = '0;
				cur_bad = 1'b1;
			end
		endcase

		// acc*10 + d as two shifts and adds; overflow past 31 bits is an error.
		acc_next = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
			+ (msfsec_pkg::ACC_W+4)'(digit);
		acc_ovf  = (acc_next[msfsec_pkg::ACC_W+3:msfsec_pkg::ACC_W] != 4'd0);

		term_bad = err_q || (fpos_q != msfsec_pkg::FIELD_FRM) || !seen_q
			|| (sec_q >= msfsec_pkg::SECS_PER_MIN)
			|| (frm_q >= msfsec_pkg::FRAMES_PER_SEC);

		// Seconds and frames are small whenever the result is good.
		rem_val = msfsec_pkg::rem_t'(sec_q[5:0]) * msfsec_pkg::FRAMES_PER_SEC_R
			+ msfsec_pkg::rem_t'(frm_q[6:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpos_q <= msfsec_pkg::FIELD_MIN;
			seen_q <= 1'b0;
			err_q  <= 1'b0;
			min_q  <= '0;
			sec_q  <= '0;
			frm_q  <= '0;
		end else if (take_s1) begin
			if (is_term) begin
				// Terminator: clear everything for the next string.
				fpos_q <= msfsec_pkg::FIELD_MIN;
				seen_q <= 1'b0;
				err_q  <= 1'b0;
				min_q  <= '0;
				sec_q  <= '0;
				frm_q  <= '0;
			end else if (!err_q) begin
				if (is_digit) begin
					if (cur_bad || acc_ovf) begin
						err_q <= 1'b1;
					end else begin
						seen_q <= 1'b1;
						case (fpos_q)
							msfsec_pkg::FIELD_MIN: min_q <= acc_next[msfsec_pkg::ACC_W-1:0];
							msfsec_pkg::FIELD_SEC: sec_q <= acc_next[msfsec_pkg::ACC_W-1:0];
							default:               frm_q <= acc_next[msfsec_pkg::ACC_W-1:0];
						endcase
					end
				end else if (is_colon) begin
					// Advance only past a field with a digit, and never past frames.
					if (fpos_q inside {msfsec_pkg::FIELD_MIN, msfsec_pkg::FIELD_SEC}
						&& seen_q) begin
						fpos_q <= fpos_q + 2'd1;
						seen_q <= 1'b0;
					end else begin
						err_q <= 1'b1;
					end
				end else begin
					err_q <= 1'b1;
				end
			end
		end
	end

	// ---------------- stage 2: snapshot of a finished string ----------------
	msfsec_pkg::acc_t min_s2;
	msfsec_pkg::rem_t rem_s2;
	logic             bad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1 && is_term;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && is_term) begin
			min_s2 <= min_q;
			rem_s2 <= rem_val;
			bad_s2 <= term_bad;
		end
	end

	// ---------------- stage 3: minutes times frames per minute ----------------
	msfsec_pkg::prod_t prod_s3;
	msfsec_pkg::rem_t  rem_s3;
	logic              bad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			prod_s3 <= msfsec_pkg::prod_t'(min_s2) * msfsec_pkg::FRAMES_PER_MIN;
			rem_s3  <= rem_s2;
			bad_s3  <= bad_s2;
		end
	end

	// ---------------- output register: add and range check ----------------
	msfsec_pkg::prod_t sum;
	logic              res_bad;

	always_comb begin
		sum     = prod_s3 + msfsec_pkg::PROD_W'(rem_s3);
		res_bad = bad_s3
			|| (sum[msfsec_pkg::PROD_W-1:msfsec_pkg::ACC_W] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (rdy_out) begin
			m_tvalid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s3) begin
			if (res_bad) begin
				m_tdata <= '0;
				m_tuser <= msfsec_pkg::STATUS_ERR;
			end else begin
				m_tdata <= {1'b0, sum[msfsec_pkg::ACC_W-1:0]};
				m_tuser <= msfsec_pkg::STATUS_OK;
			end
		end
	end

endmodule

// ===== src/msfsec_checker.sv =====
// Port-level checks for the MSF timecode to sector number converter, with bind.
module msfsec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// No result is offered after reset has been seen low at a clock edge.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result offered during reset");

	// An error result carries a zero sector number.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == msfsec_pkg::STATUS_ERR) |-> (m_tdata == '0))
		else $error("error result with nonzero sector number");

	// With the output register empty the whole pipeline drains, so input is taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output is empty");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// A stalled character holds.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
		else $error("stalled character changed");

endmodule

bind msf_timecode_to_sector_unit msfsec_checker u_msfsec_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the MSF timecode to sector number converter.
module tb_top;

	localparam longint unsigned ACC_LIMIT = 64'h7FFF_FFFF;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_CHARS = 210;
	localparam int REPORT_MAX = 10;

	// One expected output transaction: status over sector number
	typedef struct packed {
		logic status;
		msfsec_pkg::acc_t sector;
	} sector_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = msfsec_pkg::CHAR_TERM;   // [7:0] char_code
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;               // [30:0] sector_number, [31] zero
	logic        m_tuser;               // [0] status

	msfsec_pkg::char_t char_queue[$];   // characters waiting to be offered
	sector_result_t    sector_queue[$]; // sector results still owed by the block

	// Parser shadow state, advanced on every accepted character
	msfsec_pkg::field_t cur_field = msfsec_pkg::FIELD_MIN;
	logic               digit_seen = 1'b0;
	msfsec_pkg::acc_t   minutes_acc = '0;
	msfsec_pkg::acc_t   seconds_acc = '0;
	msfsec_pkg::acc_t   frames_acc = '0;
	logic               error_held = 1'b0;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int holdoff_token = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;
	int idle_cycles = 0;
	int mismatch_count = 0;

	msf_timecode_to_sector_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// Advance the shadow parser by one character; a terminator owes one result.
	task automatic parse_char(input msfsec_pkg::char_t c);
		logic bad;
		longint unsigned sum;
		longint unsigned digit;
		longint unsigned cur;
		sector_result_t res;
		if (c == msfsec_pkg::CHAR_TERM) begin
			bad = error_held || cur_field != msfsec_pkg::FIELD_FRM || !digit_seen;
			sum = 0;
			if (!bad && (seconds_acc >= msfsec_pkg::SECS_PER_MIN
				|| frames_acc >= msfsec_pkg::FRAMES_PER_SEC))
				bad = 1'b1;
			if (!bad) begin
				sum = 64'(minutes_acc) * msfsec_pkg::FRAMES_PER_MIN
					+ 64'(seconds_acc) * msfsec_pkg::FRAMES_PER_SEC
					+ 64'(frames_acc);
				if (sum > ACC_LIMIT)
					bad = 1'b1;
			end
			res.status = bad ? msfsec_pkg::STATUS_ERR : msfsec_pkg::STATUS_OK;
			res.sector = bad ? '0 : msfsec_pkg::acc_t'(sum);
			sector_queue.push_back(res);
			cur_field = msfsec_pkg::FIELD_MIN;
			digit_seen = 1'b0;
			minutes_acc = '0;
			seconds_acc = '0;
			frames_acc = '0;
			error_held = 1'b0;
		end else if (!error_held) begin
			if (c >= msfsec_pkg::CHAR_ZERO && c <= msfsec_pkg::CHAR_NINE) begin
				digit = 64'(c - msfsec_pkg::CHAR_ZERO);
				case (cur_field)
					msfsec_pkg::FIELD_MIN: cur = 64'(minutes_acc);
					msfsec_pkg::FIELD_SEC: cur = 64'(seconds_acc);
					default:               cur = 64'(frames_acc);
				endcase
				// a digit that would overflow the field is refused and poisons the string
				if (cur_field == msfsec_pkg::FIELD_UNUSED
					|| cur > (ACC_LIMIT - digit) / 10) begin
					error_held = 1'b1;
				end else begin
					cur = cur * 10 + digit;
					case (cur_field)
						msfsec_pkg::FIELD_MIN: minutes_acc = msfsec_pkg::acc_t'(cur);
						msfsec_pkg::FIELD_SEC: seconds_acc = msfsec_pkg::acc_t'(cur);
						default:               frames_acc = msfsec_pkg::acc_t'(cur);
					endcase
					digit_seen = 1'b1;
				end
			end else if (c == msfsec_pkg::CHAR_COLON) begin
				// a colon moves on only from minutes or seconds, and only after a digit
				if ((cur_field == msfsec_pkg::FIELD_MIN || cur_field == msfsec_pkg::FIELD_SEC)
					&& digit_seen) begin
					cur_field = msfsec_pkg::field_t'(cur_field + 1);
					digit_seen = 1'b0;
				end else begin
					error_held = 1'b1;
				end
			end else begin
				error_held = 1'b1;
			end
		end
	endtask

	task automatic note_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
	endtask

	// Driver: hold the character until taken, then offer the next one or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= msfsec_pkg::CHAR_TERM;
		end else if (!s_tvalid || s_tready) begin
			if (char_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= char_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long holdoff whenever the token moves.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (holdoff_left > 0) begin
			m_tready <= 1'b0;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_token != holdoff_seen) begin
			holdoff_seen <= holdoff_token;
			holdoff_left <= HOLDOFF_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: check the result transaction first, then feed the accepted character.
	always @(posedge clk) begin
		sector_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (sector_queue.size() == 0) begin
					note_mismatch("unexpected result, sector_number", 0, m_tdata[30:0]);
				end else begin
					want = sector_queue.pop_front();
					if (m_tdata !== {1'b0, want.sector})
						note_mismatch("sector_number", want.sector, m_tdata);
					if (m_tuser !== want.status)
						note_mismatch("status", want.status, m_tuser);
				end
			end
			if (s_tvalid && s_tready)
				parse_char(s_tdata);
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles < WATCHDOG_LIMIT) begin
				idle_cycles <= idle_cycles + 1;
			end else begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Queue a string followed by its terminator; return the character count.
	function automatic int push_text(input string text);
		for (int i = 0; i < text.len(); i++)
			char_queue.push_back(msfsec_pkg::char_t'(text[i]));
		char_queue.push_back(msfsec_pkg::CHAR_TERM);
		return text.len() + 1;
	endfunction

	function automatic string digit_run(input int unsigned lo, input int unsigned hi);
		string s;
		s = $sformatf("%0d", $urandom_range(hi, lo));
		if ($urandom_range(7) == 0)
			s = {"0", s};
		return s;
	endfunction

	// Long digit runs reach the field overflow check.
	function automatic string long_digits();
		string s;
		int n;
		s = "";
		n = $urandom_range(12, 8);
		for (int i = 0; i < n; i++)
			s = {s, $sformatf("%0d", $urandom_range(9))};
		return s;
	endfunction

	// Build one random timecode, mostly well formed, sometimes damaged or pure noise.
	function automatic int push_random_string();
		string text;
		msfsec_pkg::char_t q[$];
		int kind;
		int n;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2, 3, 4: text = {digit_run(0, 99), ":", digit_run(0, 59), ":",
				digit_run(0, 74)};
			5: text = {digit_run(0, 99), ":", digit_run(0, 69), ":", digit_run(0, 84)};
			6: text = {digit_run(477100, 477300), ":", digit_run(0, 59), ":",
				digit_run(0, 74)};
			7: begin
				case ($urandom_range(2))
					0: text = {long_digits(), ":", digit_run(0, 59), ":", digit_run(0, 74)};
					1: text = {digit_run(0, 99), ":", long_digits(), ":", digit_run(0, 74)};
					default: text = {digit_run(0, 99), ":", digit_run(0, 59), ":",
						long_digits()};
				endcase
			end
			default: text = "";
		endcase
		for (int i = 0; i < text.len(); i++)
			q.push_back(msfsec_pkg::char_t'(text[i]));
		if (kind > 7) begin
			// noise: arbitrary bytes, high bit included
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++)
				q.push_back(msfsec_pkg::char_t'($urandom_range(255, 1)));
		end else if ($urandom_range(3) == 0) begin
			case ($urandom_range(4))
				0: q[$urandom_range(q.size() - 1)] = msfsec_pkg::char_t'($urandom_range(255, 1));
				1: q.delete($urandom_range(q.size() - 1));
				2: q.insert($urandom_range(q.size()), msfsec_pkg::CHAR_COLON);
				3: q = q[0:$urandom_range(q.size() - 1)];
				default: q.insert($urandom_range(q.size()),
					msfsec_pkg::char_t'($urandom_range(255)));
			endcase
		end
		foreach (q[i])
			char_queue.push_back(q[i]);
		char_queue.push_back(msfsec_pkg::CHAR_TERM);
		return q.size() + 1;
	endfunction

	// Pause the sender until every owed result has come back.
	task automatic wait_drained();
		while (char_queue.size() != 0 || s_tvalid || sector_queue.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int sent;
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, range limits, overflow edges and malformed strings
		sent = push_text("0:0:0");
		sent = push_text("99:59:74");
		sent = push_text("000:00:00074");
		sent = push_text("477218:35:22");
		sent = push_text("477218:35:23");
		sent = push_text("2147483647:0:0");
		sent = push_text("2147483648:0:0");
		sent = push_text("0:0:2147483647");
		sent = push_text("0:60:0");
		sent = push_text("0:59:75");
		sent = push_text("12/3:4:5");
		sent = push_text("1;2:3");
		sent = push_text("1:2:3:");
		sent = push_text("1::2");
		sent = push_text(":1:2");
		sent = push_text("1:2");
		sent = push_text("1:2:");
		sent = push_text("");
		char_queue.push_back(msfsec_pkg::char_t'(8'hFF));
		char_queue.push_back(msfsec_pkg::char_t'(8'h80));
		sent = push_text("1:2:3");
		wait_drained();

		// random: four phases of differing sender gaps and receiver stalls, the long receiver holdoff in the first
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
					holdoff_token++;
				end
				1: begin
					send_gap_pct = 50;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 50;
				end
				default: begin
					send_gap_pct = 24;
					recv_stall_pct = 24;
				end
			endcase
			sent = 0;
			while (sent < PHASE_CHARS)
				sent += push_random_string();
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && sector_queue.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/msfsec_pkg.sv
src/msf_timecode_to_sector_unit.sv
src/msfsec_checker.sv
tb/tb_top.sv
